>>> hw/rtl/meu_pkg.sv
// Shared constants and types for the modular exponentiation unit.
package meu_pkg;

	// Default modulus / message width
	localparam int MOD_BITS_DEF = 16;
	// Exponent width, fixed
	localparam int EXP_BITS = 16;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODULUS  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_EXPONENT = 1'b1;

	// Status of the iterative remainder unit
	typedef struct packed {
		logic busy;
		logic done;
	} rem_sts_t;

endpackage

>>> hw/rtl/meu_rem.sv
// Iterative remainder unit: one restoring step per cycle over the low half.
module meu_rem #(
	parameter int MOD_BITS = meu_pkg::MOD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [2*MOD_BITS-1:0]   dividend,  // high half must be below divisor
	input  logic [MOD_BITS:0]       divisor,
	output meu_pkg::rem_sts_t       sts,
	output logic [MOD_BITS-1:0]     remainder
);

	localparam int CNT_W = $clog2(MOD_BITS + 1);

	logic [MOD_BITS:0]   rem_q;
	logic [MOD_BITS-1:0] dvd_q;
	logic [MOD_BITS:0]   div_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;

	logic [MOD_BITS+1:0] trial;
	logic [MOD_BITS+1:0] div_ext;
	logic [MOD_BITS+1:0] diff;
	logic [MOD_BITS:0]   rem_next;

	// one shift-compare-subtract step
	always_comb begin
		trial   = {rem_q, dvd_q[MOD_BITS-1]};
		div_ext = {1'b0, div_q};
		diff    = trial - div_ext;
		if (trial >= div_ext) begin
			rem_next = diff[MOD_BITS:0];
		end else begin
			rem_next = trial[MOD_BITS:0];
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(MOD_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, dividend[2*MOD_BITS-1:MOD_BITS]};
			dvd_q <= dividend[MOD_BITS-1:0];
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[MOD_BITS-2:0], 1'b0};
		end
	end

	assign sts.busy  = busy_q;
	assign sts.done  = done_q;
	assign remainder = rem_q[MOD_BITS-1:0];

endmodule

>>> hw/rtl/modular_exponentiation_unit.sv
// Top level: modular exponentiation by square-and-multiply with a shared multiplier.
//
//  channel | dir | handshake         | content
//  s_*     | in  | s_tvalid/s_tready | message word
//  m_*     | out | m_tvalid/m_tready | result word
//  cfg_*   | in  | cfg_we            | modulus (index 0), exponent (index 1)
//
// Each word takes k multiplies, k <= 2*EXP_BITS; a zero exponent skips the
// base reduction and all multiplies and returns 1.
// Each multiply is one registered product plus MOD_BITS remainder steps.
// Reset clears the sequencer; modulus and exponent reset to 1.
// s_tready is high only while idle; a finished result waits in the output
// register while the next word is already being taken.
module modular_exponentiation_unit #(
	parameter int MOD_BITS = meu_pkg::MOD_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((MOD_BITS+7)/8)*8-1:0]          s_tdata,   // [MOD_BITS-1:0] message
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [((MOD_BITS+7)/8)*8-1:0]          m_tdata,   // [MOD_BITS-1:0] result
	input  logic                                  cfg_we,
	input  logic [meu_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [((MOD_BITS > 16) ? MOD_BITS : 16)-1:0] cfg_data
);

	localparam int EXP_BITS = meu_pkg::EXP_BITS;

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_WAIT = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	// operation in flight
	localparam logic [1:0] OP_BASE = 2'd0;
	localparam logic [1:0] OP_ACC  = 2'd1;
	localparam logic [1:0] OP_SQ   = 2'd2;

	logic [MOD_BITS-1:0]   modulus_q;
	logic [EXP_BITS-1:0]   exponent_q;

	logic [2:0]            state_q;
	logic [1:0]            op_q;
	logic [EXP_BITS-1:0]   exp_q;
	logic [MOD_BITS-1:0]   acc_q;
	logic [MOD_BITS-1:0]   sq_q;
	logic [2*MOD_BITS-1:0] product_q;
	logic [MOD_BITS-1:0]   res_q;
	logic                  out_valid_q;

	logic [MOD_BITS:0]     eff_mod;
	logic [MOD_BITS-1:0]   mul_a;
	logic [2*MOD_BITS-1:0] mul_p;
	logic                  rem_start;
	meu_pkg::rem_sts_t     rem_sts;
	logic [MOD_BITS-1:0]   rem_val;
	logic [EXP_BITS-1:0]   exp_shift;
	logic                  accept;
	logic                  out_free;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= MOD_BITS'(1);
			exponent_q <= EXP_BITS'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				meu_pkg::CFG_IDX_MODULUS:  modulus_q  <= cfg_data[MOD_BITS-1:0];
				meu_pkg::CFG_IDX_EXPONENT: exponent_q <= cfg_data[EXP_BITS-1:0];
				default: ;
			endcase
		end
	end

	// zero modulus means 2^MOD_BITS
	assign eff_mod = (modulus_q == '0) ? {1'b1, {MOD_BITS{1'b0}}} : {1'b0, modulus_q};

	// shared multiplier: acc*sq or sq*sq
	assign mul_a = (op_q == OP_ACC) ? acc_q : sq_q;
	assign mul_p = (2*MOD_BITS)'(mul_a) * (2*MOD_BITS)'(sq_q);

	assign rem_start = (state_q == S_DIV);
	assign exp_shift = exp_q >> 1;
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;

	meu_rem #(
		.MOD_BITS (MOD_BITS)
	) u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (rem_start),
		.dividend  (product_q),
		.divisor   (eff_mod),
		.sts       (rem_sts),
		.remainder (rem_val)
	);

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_BASE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q    <= OP_BASE;
						state_q <= (exponent_q == '0) ? S_DONE : S_DIV;
					end
				end
				S_MUL: state_q <= S_DIV;
				S_DIV: state_q <= S_WAIT;
				S_WAIT: begin
					if (rem_sts.done) begin
						unique case (op_q)
							OP_ACC: begin
								op_q    <= OP_SQ;
								state_q <= S_MUL;
							end
							OP_SQ: begin
								if (exp_shift == '0) begin
									state_q <= S_DONE;
								end else begin
									op_q    <= exp_shift[0] ? OP_ACC : OP_SQ;
									state_q <= S_MUL;
								end
							end
							default: begin
								// base reduced; exponent known nonzero
								op_q    <= exp_q[0] ? OP_ACC : OP_SQ;
								state_q <= S_MUL;
							end
						endcase
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// sequencer datapath
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			exp_q     <= exponent_q;
			acc_q     <= MOD_BITS'(1);
			product_q <= {{MOD_BITS{1'b0}}, s_tdata[MOD_BITS-1:0]};
		end
		if (state_q == S_MUL) begin
			product_q <= mul_p;
		end
		if (state_q == S_WAIT && rem_sts.done) begin
			unique case (op_q)
				OP_ACC: acc_q <= rem_val;
				OP_SQ: begin
					sq_q  <= rem_val;
					exp_q <= exp_shift;
				end
				default: sq_q <= rem_val;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			res_q <= acc_q;
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		m_tdata = '0;
		m_tdata[MOD_BITS-1:0] = res_q;
	end

endmodule

>>> hw/rtl/meu_checker.sv
// Port-level checks for the modular exponentiation unit, bound to the top level.
module meu_checker #(
	parameter int MOD_BITS = meu_pkg::MOD_BITS_DEF
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [((MOD_BITS+7)/8)*8-1:0]    m_tdata
);

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// block goes busy right after taking a word
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready stayed high after accept");

	// ready drops only because a word was taken
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(s_tvalid))
		else $error("ready dropped without an accepted word");

	// a new result comes only out of a busy block
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared while idle");

endmodule

bind modular_exponentiation_unit meu_checker #(
	.MOD_BITS (MOD_BITS)
) u_meu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
